### src/tcw_pkg.sv
// Shared types and constants for the text console character writer.
package tcw_pkg;

  // Screen geometry defaults
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths of the words on the ports
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int ADDR_W  = 11;
  localparam int CELL_W  = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 8'h07;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_addr;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_pos;
    logic [CELL_W-1:0] read_data;
    logic              scrolled;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic sweep_en;  // run one step of the screen sweep
    logic init;      // sweep is the post-reset clear
    logic load_out;  // capture the result word
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_start;  // the offered word needs a sweep (clear or scroll)
    logic sweep_done;   // last sweep step
  } dp_status_t;

endpackage

### src/tcw_ctrl.sv
// Controller state machine for the text console character writer.
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  tcw_pkg::dp_status_t status_i,
  output tcw_pkg::ctrl_cmd_t  ctrl_o
);

  localparam logic [1:0] ST_INIT   = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.sweep_en = (state_q == ST_INIT) || (state_q == ST_SWEEP);
    ctrl_o.init     = (state_q == ST_INIT);
    ctrl_o.load_out = (state_q == ST_RESULT) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.sweep_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = status_i.sweep_start ? ST_SWEEP : ST_RESULT;
      end
      ST_SWEEP: begin
        if (status_i.sweep_done) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### src/tcw_dp.sv
// Datapath of the text console character writer: screen store, cursor, sweep counter.
module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0]        cfg_wdata_i,
  input  tcw_pkg::in_word_t                  in_word_i,
  input  tcw_pkg::ctrl_cmd_t                 ctrl_i,
  output tcw_pkg::dp_status_t                status_o,
  output tcw_pkg::out_word_t                 out_word_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int COPY_N = CELLS - COLUMNS;     // cells moved up by a scroll
  localparam int AW = $clog2(CELLS);           // screen store address
  localparam int KW = $clog2(CELLS + 1);       // sweep counter, holds CELLS
  localparam int CW = $clog2(COLUMNS + 8);     // column, holds a tab overshoot
  localparam int RW = $clog2(ROWS + 1);        // row, holds ROWS before scroll

  logic [tcw_pkg::COLOR_W-1:0] text_color_q;
  logic [CW-1:0]               col_q;
  logic [RW-1:0]               row_q;
  logic [KW-1:0]               k_q;
  logic                        copy_q;
  logic                        rd_sel_q;
  logic                        scrolled_q;
  logic [tcw_pkg::CELL_W-1:0]  rd_q;
  tcw_pkg::out_word_t          out_q;

  logic [tcw_pkg::CELL_W-1:0]  mem [CELLS];

  logic is_put, is_read, is_clear;
  logic in_range;
  logic [31:0] addr32;

  // put decode
  logic [CW-1:0] col_n;
  logic [RW-1:0] row_n;
  logic [CW-1:0] wr_col;
  logic [CW-1:0] tab_sum;
  logic          put_wr;
  logic          scroll_n;
  logic [tcw_pkg::CHAR_W-1:0] put_char;
  logic [31:0]   put_pos32;
  logic [31:0]   cur_pos32;

  // memory ports
  logic                       wr_en, rd_en;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data;
  logic [KW-1:0]              k_m1;
  logic [31:0]                k_up32;
  logic [tcw_pkg::COLOR_W-1:0] blank_color;

  assign is_put   = (in_word_i.cmd == tcw_pkg::CMD_PUT);
  assign is_read  = (in_word_i.cmd == tcw_pkg::CMD_READ);
  assign is_clear = (in_word_i.cmd == tcw_pkg::CMD_CLEAR);
  assign addr32   = 32'(in_word_i.cell_addr);
  assign in_range = (addr32 < CELLS);
  assign tab_sum  = col_q + CW'(8);

  always_comb begin
    col_n    = col_q;
    row_n    = row_q;
    wr_col   = col_q;
    put_wr   = 1'b0;
    put_char = in_word_i.char_code;
    unique case (in_word_i.char_code)
      tcw_pkg::CH_NL: begin
        col_n = '0;
        row_n = row_q + 1'b1;
      end
      tcw_pkg::CH_CR: begin
        col_n = '0;
      end
      tcw_pkg::CH_TAB: begin
        col_n = {tab_sum[CW-1:3], 3'b000};
      end
      tcw_pkg::CH_BS: begin
        if (col_q != '0) col_n = col_q - 1'b1;
        wr_col   = col_n;
        put_wr   = 1'b1;
        put_char = tcw_pkg::CH_SPACE;
      end
      default: begin
        col_n  = col_q + 1'b1;
        put_wr = 1'b1;
      end
    endcase
    // wrap at the row end
    if (32'(col_n) >= COLUMNS) begin
      col_n = '0;
      row_n = row_n + 1'b1;
    end
    scroll_n = (32'(row_n) >= ROWS);
    if (scroll_n) row_n = RW'(ROWS - 1);
  end

  assign put_pos32 = 32'(row_q) * COLUMNS + 32'(wr_col);
  assign cur_pos32 = 32'(row_q) * COLUMNS + 32'(col_q);

  assign status_o.sweep_start = (is_put && scroll_n) || is_clear;
  assign status_o.sweep_done  = (k_q == KW'(CELLS));

  // Sweep: step k writes cell k-1; a scroll reads cell k+COLUMNS into rd_q, which step k+1 writes to cell k
  assign k_m1        = k_q - 1'b1;
  assign k_up32      = 32'(k_q) + COLUMNS;
  assign blank_color = ctrl_i.init ? tcw_pkg::TEXT_COLOR_RST : text_color_q;

  always_comb begin
    if (ctrl_i.sweep_en) begin
      wr_en   = (k_q != '0);
      wr_addr = k_m1[AW-1:0];
      if (copy_q && (32'(k_q) <= COPY_N)) begin
        wr_data = rd_q;
      end else begin
        wr_data = {blank_color, tcw_pkg::CH_SPACE};
      end
      rd_en   = copy_q && (32'(k_q) < COPY_N);
      rd_addr = k_up32[AW-1:0];
    end else begin
      wr_en   = ctrl_i.accept && is_put && put_wr;
      wr_addr = put_pos32[AW-1:0];
      wr_data = {text_color_q, put_char};
      rd_en   = ctrl_i.accept && is_read && in_range;
      rd_addr = addr32[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcw_pkg::TEXT_COLOR_RST;
      col_q        <= '0;
      row_q        <= '0;
      k_q          <= '0;
      copy_q       <= 1'b0;
      rd_sel_q     <= 1'b0;
      scrolled_q   <= 1'b0;
    end else begin
      if (cfg_we_i) text_color_q <= cfg_wdata_i;
      if (ctrl_i.sweep_en) begin
        k_q <= status_o.sweep_done ? '0 : k_q + 1'b1;
      end
      if (ctrl_i.accept) begin
        copy_q     <= is_put;
        rd_sel_q   <= is_read && in_range;
        scrolled_q <= is_put && scroll_n;
        if (is_put) begin
          col_q <= col_n;
          row_q <= row_n;
        end else if (is_clear) begin
          col_q <= '0;
          row_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_q.cursor_pos <= cur_pos32[tcw_pkg::ADDR_W-1:0];
      out_q.read_data  <= rd_sel_q ? rd_q : '0;
      out_q.scrolled   <= scrolled_q;
    end
  end

  assign out_word_o = out_q;

endmodule

### src/text_console_char_writer_unit.sv
// Top level of the text console character writer: controller, datapath and checks.
//
// Text-mode console engine over a COLUMNS x ROWS screen of 16-bit cells
// (character in the low byte, color in the high byte). Each input word is a
// put, read or clear command and yields exactly one output word carrying the
// cursor position after the command, the cell read (zero otherwise) and a
// scroll flag. A put that does not scroll, a read and an unused command
// are accepted and then loaded into the output register once it is free.
// A clear, or a put that scrolls, walks the whole screen store through its
// single write port, one cell per cycle, before its result is loaded; the
// input is stalled meanwhile. After reset the screen store is blanked by
// the same walk before the first word is taken; text_color writes are
// taken during that time. The output word sits in a register, so a new
// input word is taken while an earlier result still waits on a stalled
// output.
module text_console_char_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: text color
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0] cfg_wdata_i,
  // command words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tcw_pkg::in_word_t           in_word_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tcw_pkg::out_word_t          out_word_o
);

  tcw_pkg::ctrl_cmd_t  ctrl;
  tcw_pkg::dp_status_t status;

  // Sequence accept, sweep and result load
  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // Hold the screen store, cursor and result word
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_word_o  (out_word_o)
  );

  // No word may be taken while the screen store is being walked
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.sweep_en |-> in_stall_o)
    else $error("input word taken during screen sweep");

  // Loading a result never overwrites a word still stalled on the output
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |-> !(out_valid_o && out_stall_i))
    else $error("result word overwritten while stalled");

  // A scrolling put never reports read data
  a_scroll_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.scrolled) |-> (out_word_o.read_data == '0))
    else $error("scroll result carries read data");

  // Reported cursor stays on the screen
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_word_o.cursor_pos) < COLUMNS * ROWS))
    else $error("cursor position off the screen");

endmodule
